>>> rtl/ucp_pkg.sv
// Shared types, constants and color word tables for the color/power command parser.
package ucp_pkg;

	// Byte codes
	localparam logic [7:0] BYTE_CR        = 8'h0D;
	localparam logic [7:0] BYTE_NUL       = 8'h00;
	localparam logic [7:0] BYTE_LETTER_LO = 8'h41;
	localparam logic [7:0] BYTE_LETTER_HI = 8'h7A;
	localparam logic [7:0] BYTE_DIGIT_LO  = 8'h30;
	localparam logic [7:0] BYTE_DIGIT_HI  = 8'h39;

	localparam logic [6:0] POWER_MAX = 7'd100;

	// Color words
	localparam int COLOUR_KINDS = 4;
	localparam logic [1:0] COLOUR_GREEN  = 2'd0;
	localparam logic [1:0] COLOUR_RED    = 2'd1;
	localparam logic [1:0] COLOUR_BLUE   = 2'd2;
	localparam logic [1:0] COLOUR_ORANGE = 2'd3;

	// Token queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Byte classes produced by the front end
	typedef enum logic [2:0] {
		TOK_SKIP,
		TOK_LETTER,
		TOK_DIGIT,
		TOK_STOP,
		TOK_EOL
	} tok_kind_t;

	// One classified byte: letter byte or digit value in data
	typedef struct packed {
		tok_kind_t  kind;
		logic [7:0] data;
	} token_t;

	// Length of each color word
	function automatic logic [2:0] colour_len(input logic [1:0] k);
		logic [2:0] len;
		case (k)
			COLOUR_GREEN:  len = 3'd5;
			COLOUR_RED:    len = 3'd3;
			COLOUR_BLUE:   len = 3'd4;
			COLOUR_ORANGE: len = 3'd6;
			default:       len = 3'd0;
		endcase
		return len;
	endfunction

	// Letter at position pos of color word k
	function automatic logic [7:0] colour_char(input logic [1:0] k, input logic [2:0] pos);
		logic [7:0] c;
		c = 8'h00;
		case (k)
			COLOUR_GREEN: begin
				case (pos)
					3'd0:    c = "g";
					3'd1:    c = "r";
					3'd2:    c = "e";
					3'd3:    c = "e";
					3'd4:    c = "n";
					default: c = 8'h00;
				endcase
			end
			COLOUR_RED: begin
				case (pos)
					3'd0:    c = "r";
					3'd1:    c = "e";
					3'd2:    c = "d";
					default: c = 8'h00;
				endcase
			end
			COLOUR_BLUE: begin
				case (pos)
					3'd0:    c = "b";
					3'd1:    c = "l";
					3'd2:    c = "u";
					3'd3:    c = "e";
					default: c = 8'h00;
				endcase
			end
			COLOUR_ORANGE: begin
				case (pos)
					3'd0:    c = "o";
					3'd1:    c = "r";
					3'd2:    c = "a";
					3'd3:    c = "n";
					3'd4:    c = "g";
					3'd5:    c = "e";
					default: c = 8'h00;
				endcase
			end
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

>>> rtl/ucp_front.sv
// Front end: classifies each received byte into a parser token.
module ucp_front (
	input  logic [7:0]      rx_byte,
	output ucp_pkg::token_t tok
);

	// Byte classification
	always_comb begin
		tok.data = rx_byte;
		if (rx_byte == ucp_pkg::BYTE_CR) begin
			tok.kind = ucp_pkg::TOK_EOL;
		end else if (rx_byte == ucp_pkg::BYTE_NUL) begin
			tok.kind = ucp_pkg::TOK_STOP;
		end else if (rx_byte >= ucp_pkg::BYTE_LETTER_LO && rx_byte <= ucp_pkg::BYTE_LETTER_HI) begin
			tok.kind = ucp_pkg::TOK_LETTER;
		end else if (rx_byte >= ucp_pkg::BYTE_DIGIT_LO && rx_byte <= ucp_pkg::BYTE_DIGIT_HI) begin
			tok.kind = ucp_pkg::TOK_DIGIT;
			tok.data = rx_byte - ucp_pkg::BYTE_DIGIT_LO;
		end else begin
			tok.kind = ucp_pkg::TOK_SKIP;
		end
	end

endmodule

>>> rtl/ucp_queue.sv
// Short token queue between the classifying front end and the executing back end.
module ucp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  ucp_pkg::token_t push_tok,
	output logic            pop_valid,
	input  logic            pop_ready,
	output ucp_pkg::token_t pop_tok
);

	ucp_pkg::token_t                 mem_q [ucp_pkg::QUEUE_DEPTH];
	logic [ucp_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [ucp_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [ucp_pkg::QCNT_W-1:0]      count_q;
	logic                            push;
	logic                            pop;

	assign push_ready = (count_q != ucp_pkg::QCNT_W'(ucp_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_tok    = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_tok;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + ucp_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + ucp_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + ucp_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - ucp_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

>>> rtl/ucp_back.sv
// Back end: applies tokens to the line state and registers one result per line end.
module ucp_back #(
	parameter int LINE_CAPACITY = 100,
	parameter int NAME_CAPACITY = 10
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            tok_valid,
	output logic            tok_ready,
	input  ucp_pkg::token_t tok,
	output logic            out_valid,
	input  logic            out_ready,
	output logic            accepted,
	output logic [1:0]      color_code,
	output logic [6:0]      power_pct
);

	localparam int LEN_W  = $clog2(LINE_CAPACITY + 1);
	localparam int NAME_W = $clog2(NAME_CAPACITY + 1);

	// Line state
	logic [LEN_W-1:0]                  len_q;
	logic                              stop_q;
	logic [NAME_W-1:0]                 cnt_q;
	logic [ucp_pkg::COLOUR_KINDS-1:0]  match_q;
	logic [6:0]                        num_q;
	logic                              over_q;

	logic [LEN_W-1:0]                  len_d;
	logic                              stop_d;
	logic [NAME_W-1:0]                 cnt_d;
	logic [ucp_pkg::COLOUR_KINDS-1:0]  match_d;
	logic [6:0]                        num_d;
	logic                              over_d;

	logic                              out_valid_q;
	logic                              out_free;
	logic                              take;
	logic                              is_eol;
	logic [9:0]                        num_next;
	logic                              found;
	logic [1:0]                        found_k;

	assign out_free  = !out_valid_q || out_ready;
	assign is_eol    = (tok.kind == ucp_pkg::TOK_EOL);
	assign tok_ready = !is_eol || out_free;
	assign take      = tok_valid && tok_ready;
	assign out_valid = out_valid_q;

	// Times ten plus digit
	assign num_next = {num_q, 3'b000} + {2'b00, num_q, 1'b0} + {2'b00, tok.data};

	// Color lookup at line end: word lengths differ, so at most one hits
	always_comb begin
		found   = 1'b0;
		found_k = ucp_pkg::COLOUR_GREEN;
		for (int k = 0; k < ucp_pkg::COLOUR_KINDS; k++) begin
			if (match_q[k] && cnt_q == NAME_W'(ucp_pkg::colour_len(2'(k)))) begin
				found   = 1'b1;
				found_k = 2'(k);
			end
		end
	end

	// Next line state
	always_comb begin
		len_d   = len_q;
		stop_d  = stop_q;
		cnt_d   = cnt_q;
		match_d = match_q;
		num_d   = num_q;
		over_d  = over_q;
		if (take) begin
			if (is_eol) begin
				len_d   = '0;
				stop_d  = 1'b0;
				cnt_d   = '0;
				match_d = '1;
				num_d   = '0;
				over_d  = 1'b0;
			end else if (len_q < LEN_W'(LINE_CAPACITY)) begin
				len_d = len_q + LEN_W'(1);
				if (!stop_q) begin
					case (tok.kind)
						ucp_pkg::TOK_STOP: begin
							stop_d = 1'b1;
						end
						ucp_pkg::TOK_LETTER: begin
							if (cnt_q < NAME_W'(NAME_CAPACITY)) begin
								cnt_d = cnt_q + NAME_W'(1);
								for (int k = 0; k < ucp_pkg::COLOUR_KINDS; k++) begin
									match_d[k] = match_q[k]
										&& (cnt_q < NAME_W'(ucp_pkg::colour_len(2'(k))))
										&& (tok.data == ucp_pkg::colour_char(2'(k), cnt_q[2:0]));
								end
							end
						end
						ucp_pkg::TOK_DIGIT: begin
							if (!over_q) begin
								if (num_next > 10'(ucp_pkg::POWER_MAX)) begin
									num_d  = ucp_pkg::POWER_MAX;
									over_d = 1'b1;
								end else begin
									num_d = num_next[6:0];
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
		end
	end

	// Line state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			stop_q  <= 1'b0;
			cnt_q   <= '0;
			match_q <= '1;
			num_q   <= '0;
			over_q  <= 1'b0;
		end else begin
			len_q   <= len_d;
			stop_q  <= stop_d;
			cnt_q   <= cnt_d;
			match_q <= match_d;
			num_q   <= num_d;
			over_q  <= over_d;
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && is_eol) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (take && is_eol) begin
			accepted   <= found && !over_q;
			color_code <= (found && !over_q) ? found_k : 2'd0;
			power_pct  <= (found && !over_q) ? num_q : 7'd0;
		end
	end

endmodule

>>> rtl/uart_color_power_command_parser_unit.sv
// Top level of the color/power command parser: front end, token queue, back end.
// Takes one received byte per transaction and gives one result per carriage return:
// whether the line named green, red, blue or orange with a power of at most 100,
// the color code and the power. A byte is taken every cycle while the two-entry
// token queue has room; the back end retires one token per cycle unless a line end
// waits, so the sustained rate is one byte per clock while results are taken. A
// return's result goes through the token queue and the result register; only a line
// end waits while it is still occupied, and the queue then absorbs one further byte.
module uart_color_power_command_parser_unit #(
	parameter int LINE_CAPACITY = 100,
	parameter int NAME_CAPACITY = 10
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       accepted,
	output logic [1:0] color_code,
	output logic [6:0] power_pct
);

	ucp_pkg::token_t front_tok;
	ucp_pkg::token_t back_tok;
	logic            back_valid;
	logic            back_ready;

	// Classify
	ucp_front u_front (
		.rx_byte (rx_byte),
		.tok     (front_tok)
	);

	// Decouple
	ucp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (in_valid),
		.push_ready (in_ready),
		.push_tok   (front_tok),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_tok    (back_tok)
	);

	// Execute
	ucp_back #(
		.LINE_CAPACITY (LINE_CAPACITY),
		.NAME_CAPACITY (NAME_CAPACITY)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.tok_valid  (back_valid),
		.tok_ready  (back_ready),
		.tok        (back_tok),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.accepted   (accepted),
		.color_code (color_code),
		.power_pct  (power_pct)
	);

endmodule

>>> tb/sv/ucp_line_checker.sv
// Line checker for the color/power command parser: tracks line state, predicts and compares results.
module ucp_line_checker #(
	parameter int LINE_CAP = 100,
	parameter int NAME_CAP = 10
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic       accepted,
	input  logic [1:0] color_code,
	input  logic [6:0] power_pct,
	output int         fail_count,
	output int         pending
);

	typedef struct packed {
		logic       acc;
		logic [1:0] colour;
		logic [6:0] power;
	} line_result_t;

	// Results still owed by the block, oldest first
	line_result_t line_results_q[$];

	// Current line state
	logic [7:0] line_letters [NAME_CAP];
	logic [3:0] letters_seen;
	logic [6:0] power_acc;
	logic       power_over;
	logic [6:0] line_len;
	logic       line_halted;

	task automatic clear_line_state();
		int i;
		for (i = 0; i < NAME_CAP; i++)
			line_letters[i] = 8'h00;
		letters_seen = '0;
		power_acc    = '0;
		power_over   = 1'b0;
		line_len     = '0;
		line_halted  = 1'b0;
	endtask

	// Exact match of the gathered name against the four color words; -1 if none
	function automatic int colour_of_name();
		logic [47:0] w;
		int i;
		w = '0;
		if (letters_seen > 6)
			return -1;
		for (i = 0; i < letters_seen; i++)
			w = {w[39:0], line_letters[i]};
		if (letters_seen == 5 && w[39:0] == "green")
			return ucp_pkg::COLOUR_GREEN;
		if (letters_seen == 3 && w[23:0] == "red")
			return ucp_pkg::COLOUR_RED;
		if (letters_seen == 4 && w[31:0] == "blue")
			return ucp_pkg::COLOUR_BLUE;
		if (letters_seen == 6 && w == "orange")
			return ucp_pkg::COLOUR_ORANGE;
		return -1;
	endfunction

	// Advance the line state by one byte; a carriage return queues a result
	task automatic take_byte(input logic [7:0] b);
		line_result_t r;
		int c;
		int v;
		if (b == ucp_pkg::BYTE_CR) begin
			c = colour_of_name();
			r = '0;
			if (c >= 0 && !power_over) begin
				r.acc    = 1'b1;
				r.colour = c[1:0];
				r.power  = power_acc;
			end
			line_results_q.push_back(r);
			clear_line_state();
		end else if (line_len < LINE_CAP) begin
			line_len = line_len + 7'd1;
			if (!line_halted) begin
				if (b == ucp_pkg::BYTE_NUL) begin
					line_halted = 1'b1;
				end else if (b >= ucp_pkg::BYTE_LETTER_LO && b <= ucp_pkg::BYTE_LETTER_HI) begin
					if (letters_seen < NAME_CAP) begin
						line_letters[letters_seen] = b;
						letters_seen = letters_seen + 4'd1;
					end
				end else if (b >= ucp_pkg::BYTE_DIGIT_LO && b <= ucp_pkg::BYTE_DIGIT_HI) begin
					if (!power_over) begin
						v = int'(power_acc) * 10 + int'(b) - int'(ucp_pkg::BYTE_DIGIT_LO);
						if (v > int'(ucp_pkg::POWER_MAX)) begin
							power_acc  = ucp_pkg::POWER_MAX;
							power_over = 1'b1;
						end else begin
							power_acc = v[6:0];
						end
					end
				end
			end
		end
	endtask

	// Compare one result transaction with the oldest expectation
	task automatic check_result();
		line_result_t e;
		if (line_results_q.size() == 0) begin
			fail_count++;
			$display("%0t: result with nothing expected: accepted %0b color %0d power %0d",
				$time, accepted, color_code, power_pct);
		end else begin
			e = line_results_q.pop_front();
			if (accepted !== e.acc) begin
				fail_count++;
				$display("%0t: accepted expected %0b got %0b", $time, e.acc, accepted);
			end
			if (color_code !== e.colour) begin
				fail_count++;
				$display("%0t: color_code expected %0d got %0d", $time, e.colour, color_code);
			end
			if (power_pct !== e.power) begin
				fail_count++;
				$display("%0t: power_pct expected %0d got %0d", $time, e.power, power_pct);
			end
		end
	endtask

	// Watch both channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_line_state();
			line_results_q.delete();
			fail_count = 0;
		end else begin
			if (out_valid && out_ready)
				check_result();
			if (in_valid && in_ready)
				take_byte(rx_byte);
		end
		pending = line_results_q.size();
	end

endmodule

>>> tb/sv/tb_top.sv
// Testbench top for the color/power command parser: byte stimulus, result stalls, verdict.
module tb_top;

	localparam int LINE_CAP    = 100;
	localparam int NAME_CAP    = 10;
	localparam int CLK_HALF    = 6;
	localparam int ITEM_TARGET = 1900;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_LIMIT = 50000;

	typedef enum int {
		PH_SLOW_RX,
		PH_SLOW_TX,
		PH_FULL_RATE
	} phase_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] rx_byte;
	logic       out_valid;
	logic       out_ready;
	logic       accepted;
	logic [1:0] color_code;
	logic [6:0] power_pct;

	int     fail_count;
	int     pending;
	phase_t phase       = PH_SLOW_RX;
	int     tx_idle_pct = 31;
	int     rx_idle_pct = 85;
	int     items_sent  = 0;
	int     hold_left   = 0;
	bit     hold_done   = 1'b0;

	byte unsigned line_buf[$];
	string colour_words[4] = '{"green", "red", "blue", "orange"};
	string seps = " :=%,";

	always begin
		clk = 1'b0;
		#CLK_HALF;
		clk = 1'b1;
		#CLK_HALF;
	end

	uart_color_power_command_parser_unit #(
		.LINE_CAPACITY(LINE_CAP),
		.NAME_CAPACITY(NAME_CAP)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_byte   (rx_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.accepted  (accepted),
		.color_code(color_code),
		.power_pct (power_pct)
	);

	ucp_line_checker #(
		.LINE_CAP(LINE_CAP),
		.NAME_CAP(NAME_CAP)
	) i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_byte   (rx_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.accepted  (accepted),
		.color_code(color_code),
		.power_pct (power_pct),
		.fail_count(fail_count),
		.pending   (pending)
	);

	// Result side: random stalls, one long hold-off as the full-rate phase starts
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (phase == PH_FULL_RATE && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Run ends here if something hangs
	initial begin
		#(2 * CLK_HALF * 300000);
		$display("TB_ERROR");
		$finish;
	end

	// One byte transaction; entered and left at a falling edge
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	function automatic void add_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			line_buf.push_back(s[i]);
	endfunction

	function automatic void add_fill(input int n, input logic [7:0] ch);
		repeat (n)
			line_buf.push_back(ch);
	endfunction

	// Send the buffered line followed by a carriage return
	task automatic send_line();
		foreach (line_buf[i])
			send_byte(line_buf[i]);
		send_byte(ucp_pkg::BYTE_CR);
		line_buf.delete();
	endtask

	// Half well-formed commands; the rest bad letters, bad numbers, long names, stops, overflows, noise
	task automatic send_random_line();
		int pick;
		int target;
		string word;
		string num;
		logic [7:0] b;
		pick = $urandom_range(99);
		word = colour_words[$urandom_range(3)];
		num  = $sformatf("%0d", $urandom_range(100));
		if (pick < 86) begin
			if (pick < 10)
				word.putc($urandom_range(word.len() - 1),
					byte'($urandom_range(ucp_pkg::BYTE_LETTER_LO, ucp_pkg::BYTE_LETTER_HI)));
			else if (pick >= 60 && pick < 68)
				num = $sformatf("%0d", $urandom_range(101, 99999));
			else if (pick >= 68 && pick < 76)
				repeat ($urandom_range(1, 9))
					word = $sformatf("%s%c", word,
						byte'($urandom_range(ucp_pkg::BYTE_LETTER_LO,
							ucp_pkg::BYTE_LETTER_HI)));
			if ($urandom_range(7) == 0)
				num = {"0", num};
			if ($urandom_range(9) == 0) begin
				add_text(num);
				if ($urandom_range(1))
					line_buf.push_back(seps[$urandom_range(seps.len() - 1)]);
				add_text(word);
			end else begin
				add_text(word);
				if ($urandom_range(1))
					line_buf.push_back(seps[$urandom_range(seps.len() - 1)]);
				add_text(num);
			end
			// zero byte somewhere in the line
			if (pick >= 76 && pick < 84)
				line_buf.insert($urandom_range(line_buf.size()), ucp_pkg::BYTE_NUL);
			// run past the line capacity, trailing digits then dropped or not
			if (pick >= 84) begin
				target = $urandom_range(96, 112);
				while (line_buf.size() < target)
					line_buf.push_back(" ");
				add_text($sformatf("%0d", $urandom_range(9)));
			end
		end else begin
			repeat ($urandom_range(12)) begin
				do
					b = 8'($urandom_range(255));
				while (b == ucp_pkg::BYTE_CR);
				line_buf.push_back(b);
			end
		end
		send_line();
	endtask

	// Stimulus and verdict
	initial begin
		int waited;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		rx_byte   = 8'h00;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed lines: each color, power extremes, and the special cases
		add_text("green100"); send_line();
		add_text("red0"); send_line();
		add_text("blue7"); send_line();
		add_text("orange55"); send_line();
		send_line();
		add_text("red101"); send_line();
		add_text("blue999"); send_line();
		add_text("greenxxxx9"); send_line();
		add_text("orangeorange3"); send_line();
		add_text("Red5"); send_line();
		add_text("gr0een"); send_line();
		add_text("red5"); line_buf.push_back(ucp_pkg::BYTE_NUL); add_text("x200"); send_line();
		add_text("blu"); line_buf.push_back(ucp_pkg::BYTE_NUL); add_text("e3"); send_line();
		// line full: digit after the capacity is dropped
		add_text("blue"); add_fill(96, " "); add_text("7"); send_line();
		// last digit exactly at the capacity counts
		add_text("red"); add_fill(96, "."); add_text("95"); send_line();
		add_text("[\\]^_`green"); send_line();
		add_text("red"); line_buf.push_back(8'hFF); add_text("{|}~");
		line_buf.push_back(8'h80); add_text("12"); send_line();
		add_text("0100orange"); send_line();
		add_text("green1000"); send_line();
		add_text("Az9"); send_line();
		send_line();

		// random lines in three stall regimes
		while (items_sent < ITEM_TARGET / 3)
			send_random_line();
		phase       = PH_SLOW_TX;
		tx_idle_pct = 85;
		rx_idle_pct = 31;
		while (items_sent < 2 * ITEM_TARGET / 3)
			send_random_line();
		phase       = PH_FULL_RATE;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		while (items_sent < ITEM_TARGET)
			send_random_line();
		in_valid <= 1'b0;

		// drain outstanding results
		waited = 0;
		while (pending != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (8) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
